>>> src/decsc_pkg.sv
// ----------------------------------------------------------------------------
// decsc_pkg
// Shared types and constants for the debounced encoder step counter:
// beat payloads, command and register index codes, reset values.
// ----------------------------------------------------------------------------
package decsc_pkg;

  localparam int TIME_WIDTH_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int FIELD_WIDTH     = 32;
  localparam int CFG_DATA_WIDTH  = 32;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam logic [FIELD_WIDTH-1:0] SAMPLE_PERIOD_RESET = 32'd1000;

  typedef enum logic [1:0] {
    CMD_TICK       = 2'd0,
    CMD_SPEED_POLL = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SAMPLE_PERIOD = 3'd0,
    REG_COUNT_DIR     = 3'd1,
    REG_STEPS_EN      = 3'd2,
    REG_STEPS_PERIOD  = 3'd3,
    REG_SPEED_EN      = 3'd4,
    REG_SPEED_PERIOD  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    cmd_t                   cmd;
    logic [FIELD_WIDTH-1:0] now_us;
    logic                   pin_level;
  } decsc_in_t;

  typedef struct packed {
    logic                          sampled;
    logic [FIELD_WIDTH-1:0]        positive_count;
    logic [FIELD_WIDTH-1:0]        negative_count;
    logic signed [FIELD_WIDTH-1:0] net_steps;
    logic                          steps_report_valid;
    logic                          speed_valid;
    logic signed [FIELD_WIDTH-1:0] speed_steps;
    logic [FIELD_WIDTH-1:0]        speed_duration_us;
  } decsc_out_t;

endpackage

>>> src/debounced_encoder_step_counter_unit.sv
// ----------------------------------------------------------------------------
// debounced_encoder_step_counter_unit
// An accepted input beat is held in the input register and loads the result
//   register when that register is empty or its result is taken.
// Throughput: one beat per cycle; the input register and the result register
//   together hold two beats, so the input stalls only when both are full.
// Reset (rst_n low, synchronous): counters, debounce, report timing and
//   configuration return to their reset values; both stages empty.
// ----------------------------------------------------------------------------
module debounced_encoder_step_counter_unit #(
  parameter int TIME_WIDTH  = decsc_pkg::TIME_WIDTH_DEF,
  parameter int COUNT_WIDTH = decsc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  decsc_pkg::decsc_in_t                   in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output decsc_pkg::decsc_out_t                  out_data,
  input  logic                                   cfg_wr_en,
  input  logic [decsc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [decsc_pkg::CFG_DATA_WIDTH-1:0]   cfg_wdata
);

  localparam int FW = decsc_pkg::FIELD_WIDTH;
  localparam int TX = (TIME_WIDTH > FW) ? TIME_WIDTH : FW;

  // configuration
  logic [FW-1:0]          sample_period_r;
  logic                   count_dir_r;
  logic                   steps_en_r;
  logic [FW-1:0]          steps_period_r;
  logic                   speed_en_r;
  logic [FW-1:0]          speed_period_r;

  // pipeline
  logic                   s1_valid_r;
  decsc_pkg::decsc_in_t   s1_data_r;
  logic                   out_valid_r;
  decsc_pkg::decsc_out_t  out_data_r;
  decsc_pkg::decsc_out_t  out_data_nxt;
  logic                   advance;

  // counter state
  logic [TIME_WIDTH-1:0]  last_sample_r,  last_sample_nxt;
  logic                   held_level_r,   held_level_nxt;
  logic                   confirming_r,   confirming_nxt;
  logic [COUNT_WIDTH-1:0] pos_r,          pos_nxt;
  logic [COUNT_WIDTH-1:0] neg_r,          neg_nxt;
  logic [TIME_WIDTH-1:0]  steps_time_r,   steps_time_nxt;
  logic                   steps_arm_r,    steps_arm_nxt;
  logic [TIME_WIDTH-1:0]  speed_time_r,   speed_time_nxt;
  logic [COUNT_WIDTH-1:0] snap_pos_r,     snap_pos_nxt;
  logic [COUNT_WIDTH-1:0] snap_neg_r,     snap_neg_nxt;
  logic                   speed_arm_r,    speed_arm_nxt;

  logic [TIME_WIDTH-1:0]  now_t;
  logic [TIME_WIDTH-1:0]  steps_base;
  logic [TIME_WIDTH-1:0]  speed_base;
  logic [COUNT_WIDTH-1:0] base_pos;
  logic [COUNT_WIDTH-1:0] base_neg;
  logic [TIME_WIDTH-1:0]  spd_dur;
  logic [COUNT_WIDTH-1:0] spd_steps;
  logic                   sample_due;
  logic                   take_speed;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign now_t      = TIME_WIDTH'(s1_data_r.now_us);
  assign sample_due = TX'(TIME_WIDTH'(now_t - last_sample_r)) >= TX'(sample_period_r);

  always_comb begin
    last_sample_nxt = last_sample_r;
    held_level_nxt  = held_level_r;
    confirming_nxt  = confirming_r;
    pos_nxt         = pos_r;
    neg_nxt         = neg_r;
    steps_time_nxt  = steps_time_r;
    steps_arm_nxt   = steps_arm_r;
    speed_time_nxt  = speed_time_r;
    snap_pos_nxt    = snap_pos_r;
    snap_neg_nxt    = snap_neg_r;
    speed_arm_nxt   = speed_arm_r;
    steps_base      = steps_time_r;
    speed_base      = speed_time_r;
    base_pos        = snap_pos_r;
    base_neg        = snap_neg_r;
    take_speed      = 1'b0;
    out_data_nxt    = '0;

    case (s1_data_r.cmd)
      decsc_pkg::CMD_TICK: begin
        if (sample_due) begin
          out_data_nxt.sampled = 1'b1;
          last_sample_nxt      = now_t;
          if (confirming_r) begin
            if (s1_data_r.pin_level == held_level_r) begin
              confirming_nxt = 1'b0;
              if (!count_dir_r && s1_data_r.pin_level) begin
                pos_nxt = pos_r + COUNT_WIDTH'(1);
              end else if (count_dir_r && !s1_data_r.pin_level) begin
                neg_nxt = neg_r + COUNT_WIDTH'(1);
              end
            end else begin
              held_level_nxt = s1_data_r.pin_level;
            end
          end else if (s1_data_r.pin_level != held_level_r) begin
            held_level_nxt = s1_data_r.pin_level;
            confirming_nxt = 1'b1;
          end

          if (steps_en_r) begin
            if (steps_arm_r) begin
              steps_base = now_t;
            end
            steps_arm_nxt  = 1'b0;
            steps_time_nxt = steps_base;
            if (TX'(TIME_WIDTH'(now_t - steps_base)) >= TX'(steps_period_r)) begin
              out_data_nxt.steps_report_valid = 1'b1;
              steps_time_nxt                  = now_t;
            end
          end

          if (speed_en_r) begin
            if (speed_arm_r) begin
              speed_base = now_t;
              base_pos   = pos_nxt;
              base_neg   = neg_nxt;
            end
            speed_arm_nxt  = 1'b0;
            speed_time_nxt = speed_base;
            snap_pos_nxt   = base_pos;
            snap_neg_nxt   = base_neg;
            if (TX'(TIME_WIDTH'(now_t - speed_base)) >= TX'(speed_period_r)) begin
              take_speed = 1'b1;
            end
          end
        end
      end
      decsc_pkg::CMD_SPEED_POLL: begin
        if (!speed_en_r) begin
          take_speed = 1'b1;
        end
      end
      decsc_pkg::CMD_CLEAR: begin
        confirming_nxt = 1'b0;
        pos_nxt        = '0;
        neg_nxt        = '0;
        snap_pos_nxt   = '0;
        snap_neg_nxt   = '0;
      end
      default: begin
      end
    endcase

    spd_dur   = TIME_WIDTH'(now_t - speed_base);
    spd_steps = COUNT_WIDTH'(pos_nxt - base_pos) - COUNT_WIDTH'(neg_nxt - base_neg);
    if (take_speed) begin
      out_data_nxt.speed_valid       = 1'b1;
      out_data_nxt.speed_steps       = FW'(spd_steps);
      out_data_nxt.speed_duration_us = FW'(spd_dur);
      snap_pos_nxt                   = pos_nxt;
      snap_neg_nxt                   = neg_nxt;
      speed_time_nxt                 = now_t;
    end

    out_data_nxt.positive_count = FW'(pos_nxt);
    out_data_nxt.negative_count = FW'(neg_nxt);
    out_data_nxt.net_steps      = FW'(COUNT_WIDTH'(pos_nxt - neg_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!s1_valid_r || advance) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!s1_valid_r || advance) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= decsc_pkg::SAMPLE_PERIOD_RESET;
      count_dir_r     <= 1'b0;
      steps_en_r      <= 1'b0;
      steps_period_r  <= '0;
      speed_en_r      <= 1'b0;
      speed_period_r  <= '0;
      last_sample_r   <= '0;
      held_level_r    <= 1'b0;
      confirming_r    <= 1'b0;
      pos_r           <= '0;
      neg_r           <= '0;
      steps_time_r    <= '0;
      steps_arm_r     <= 1'b1;
      speed_time_r    <= '0;
      snap_pos_r      <= '0;
      snap_neg_r      <= '0;
      speed_arm_r     <= 1'b1;
    end else begin
      if (advance) begin
        last_sample_r <= last_sample_nxt;
        held_level_r  <= held_level_nxt;
        confirming_r  <= confirming_nxt;
        pos_r         <= pos_nxt;
        neg_r         <= neg_nxt;
        steps_time_r  <= steps_time_nxt;
        steps_arm_r   <= steps_arm_nxt;
        speed_time_r  <= speed_time_nxt;
        snap_pos_r    <= snap_pos_nxt;
        snap_neg_r    <= snap_neg_nxt;
        speed_arm_r   <= speed_arm_nxt;
      end
      if (cfg_wr_en) begin
        case (decsc_pkg::cfg_idx_t'(cfg_index))
          decsc_pkg::REG_SAMPLE_PERIOD: sample_period_r <= cfg_wdata;
          decsc_pkg::REG_COUNT_DIR:     count_dir_r     <= cfg_wdata[0];
          decsc_pkg::REG_STEPS_EN: begin
            steps_en_r <= cfg_wdata[0];
            if (cfg_wdata[0]) begin
              steps_arm_r <= 1'b1;
            end
          end
          decsc_pkg::REG_STEPS_PERIOD:  steps_period_r  <= cfg_wdata;
          decsc_pkg::REG_SPEED_EN: begin
            speed_en_r <= cfg_wdata[0];
            if (cfg_wdata[0]) begin
              speed_arm_r <= 1'b1;
            end
          end
          decsc_pkg::REG_SPEED_PERIOD:  speed_period_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // a held beat in the input register stays put until it moves on
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register lost or changed a held beat");

  // periodic step reports only come from sampled ticks
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.steps_report_valid |-> out_data_r.sampled)
    else $error("step report without a sample");

  // a counted step always ends the confirmation
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && (pos_nxt != pos_r || neg_nxt != neg_r) &&
    s1_data_r.cmd != decsc_pkg::CMD_CLEAR |-> !confirming_nxt)
    else $error("step counted while still confirming");

  // counters move by at most one step per beat outside a clear
  assert property (@(posedge clk) disable iff (!rst_n)
    advance && s1_data_r.cmd != decsc_pkg::CMD_CLEAR |=>
    (pos_r == $past(pos_r) || pos_r == $past(pos_r) + COUNT_WIDTH'(1)) &&
    (neg_r == $past(neg_r) || neg_r == $past(neg_r) + COUNT_WIDTH'(1)))
    else $error("counter jumped by more than one");

endmodule
